// File: design/rotm_pkg.sv
package rotm_pkg;

   // number formats
   localparam int ANGLE_W         = 16;
   localparam int ELEM_W          = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int ELEM_FRAC_BITS  = 14;
   localparam int QF              = 30;
   localparam int CORDIC_STEPS    = 28;

   // internal widths
   localparam int ZW = 36;            // angle and residual angle
   localparam int XW = 34;            // cordic x and y
   localparam int TW = 32;            // cosine and sine
   localparam int RW = TW + 1;        // first product rounded, sign flipped operands
   localparam int PW = 2 * RW;        // one product
   localparam int MW = PW - QF + 2;   // element after second product, rounded

   localparam logic signed [ZW-1:0] Q_PI      = ZW'(64'sd3373259426);
   localparam logic signed [ZW-1:0] Q_TWO_PI  = ZW'(64'sd6746518852);
   localparam logic signed [ZW-1:0] Q_HALF_PI = ZW'(64'sd1686629713);
   localparam logic signed [XW-1:0] CORDIC_X0 = XW'(64'sd652032874);

   // arctangent of 2^-i at 30 fractional bits
   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = ZW'(64'sd843314857);
         1:  v = ZW'(64'sd497837829);
         2:  v = ZW'(64'sd263043837);
         3:  v = ZW'(64'sd133525159);
         4:  v = ZW'(64'sd67021687);
         5:  v = ZW'(64'sd33543516);
         6:  v = ZW'(64'sd16775851);
         7:  v = ZW'(64'sd8388437);
         8:  v = ZW'(64'sd4194283);
         9:  v = ZW'(64'sd2097149);
         default: v = (i < CORDIC_STEPS) ? (ZW'(64'sd1) <<< (QF - i)) : '0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle_x;
      logic signed [ANGLE_W-1:0] angle_y;
      logic signed [ANGLE_W-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] m11;
      logic signed [ELEM_W-1:0] m12;
      logic signed [ELEM_W-1:0] m13;
      logic signed [ELEM_W-1:0] m21;
      logic signed [ELEM_W-1:0] m22;
      logic signed [ELEM_W-1:0] m23;
      logic signed [ELEM_W-1:0] m31;
      logic signed [ELEM_W-1:0] m32;
      logic signed [ELEM_W-1:0] m33;
   } rsp_type;

   typedef struct packed {
      logic signed [TW-1:0] cx;
      logic signed [TW-1:0] sx;
      logic signed [TW-1:0] cy;
      logic signed [TW-1:0] sy;
      logic signed [TW-1:0] cz;
      logic signed [TW-1:0] sz;
   } trig_type;

endpackage

// File: design/euler_xyz_rotation_matrix_core.sv
// Euler rotation matrix core: returns Rz * Ry * Rx for three angles.
//
// Request channel (req_valid, req_stall, req_payload): angles about x, y
// and z, radians in signed q3.13. A transfer happens on a rising edge with
// req_valid high and req_stall low.
// Response channel (rsp_valid, rsp_stall, rsp_payload): the nine matrix
// elements in signed q2.14, rounded and clamped to +-1.0.
//
// The pipeline is an angle wrap register, 28 cordic stages, a sign
// fixup register, then matrix products, rounding and saturation. One
// request can enter every cycle unless the output is blocked; throughput
// is one set of angles per cycle, set by the unrolled cordic and multipliers.
//
// Reset clears every valid bit; no response is pending afterwards.
// While a response is shown and rsp_stall is high, the whole pipeline
// holds and req_stall is raised; nothing is lost or repeated. Empty
// stages still advance as long as the output slot is free or taken.
module euler_xyz_rotation_matrix_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rotm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rotm_pkg::rsp_type rsp_payload
);

   logic               en;
   logic               trig_vld;
   rotm_pkg::trig_type trig;

   // pipeline moves unless the output holds a blocked result
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   rotm_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_valid),
      .in_data  (req_payload),
      .out_vld  (trig_vld),
      .out_data (trig)
   );

   rotm_matrix u_matrix (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (trig_vld),
      .in_data  (trig),
      .out_vld  (rsp_valid),
      .out_data (rsp_payload)
   );

endmodule

// File: design/rotm_cordic.sv
module rotm_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  rotm_pkg::req_type in_data,
   output logic              out_vld,
   output rotm_pkg::trig_type out_data
);

   localparam int N = rotm_pkg::CORDIC_STEPS;
   localparam int XW = rotm_pkg::XW;
   localparam int ZW = rotm_pkg::ZW;
   localparam int TW = rotm_pkg::TW;

   logic signed [rotm_pkg::ANGLE_W-1:0] ang [3];
   logic signed [XW-1:0] x_ff [3][N+1];
   logic signed [XW-1:0] y_ff [3][N+1];
   logic signed [ZW-1:0] z_ff [3][N+1];
   logic                 neg_ff [3][N+1];
   logic signed [TW-1:0] cos_ff [3];
   logic signed [TW-1:0] sin_ff [3];
   logic [N+1:0]         vld_ff;

   assign ang[0] = in_data.angle_x;
   assign ang[1] = in_data.angle_y;
   assign ang[2] = in_data.angle_z;

   // valid bits follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N:0], in_vld};
      end
   end

   genvar gl, gk;
   generate
      for (gl = 0; gl < 3; gl++) begin : g_lane
         logic signed [ZW-1:0] a_s;
         logic signed [ZW-1:0] r_s;
         logic signed [ZW-1:0] z0_in;
         logic                 n0_in;

         // scale to q30, wrap into [-pi, pi], fold into [-pi/2, pi/2]
         always_comb begin
            a_s = ZW'(ang[gl]) <<< (rotm_pkg::QF - rotm_pkg::ANGLE_FRAC_BITS);
            if (a_s > rotm_pkg::Q_PI) begin
               r_s = a_s - rotm_pkg::Q_TWO_PI;
            end else if (a_s < -rotm_pkg::Q_PI) begin
               r_s = a_s + rotm_pkg::Q_TWO_PI;
            end else begin
               r_s = a_s;
            end
            if (r_s > rotm_pkg::Q_HALF_PI) begin
               z0_in = r_s - rotm_pkg::Q_PI;
               n0_in = 1'b1;
            end else if (r_s < -rotm_pkg::Q_HALF_PI) begin
               z0_in = r_s + rotm_pkg::Q_PI;
               n0_in = 1'b1;
            end else begin
               z0_in = r_s;
               n0_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[gl][0]   <= rotm_pkg::CORDIC_X0;
               y_ff[gl][0]   <= '0;
               z_ff[gl][0]   <= z0_in;
               neg_ff[gl][0] <= n0_in;
            end
         end

         // one micro-rotation per stage
         for (gk = 0; gk < N; gk++) begin : g_step
            logic signed [XW-1:0] x_in;
            logic signed [XW-1:0] y_in;
            logic signed [ZW-1:0] z_in;

            always_comb begin
               if (z_ff[gl][gk] >= 0) begin
                  x_in = x_ff[gl][gk] - (y_ff[gl][gk] >>> gk);
                  y_in = y_ff[gl][gk] + (x_ff[gl][gk] >>> gk);
                  z_in = z_ff[gl][gk] - rotm_pkg::atan_q30(gk);
               end else begin
                  x_in = x_ff[gl][gk] + (y_ff[gl][gk] >>> gk);
                  y_in = y_ff[gl][gk] - (x_ff[gl][gk] >>> gk);
                  z_in = z_ff[gl][gk] + rotm_pkg::atan_q30(gk);
               end
            end

            always_ff @(posedge clock) begin
               if (en) begin
                  x_ff[gl][gk+1]   <= x_in;
                  y_ff[gl][gk+1]   <= y_in;
                  z_ff[gl][gk+1]   <= z_in;
                  neg_ff[gl][gk+1] <= neg_ff[gl][gk];
               end
            end
         end

         // undo the fold
         logic signed [XW-1:0] c_in;
         logic signed [XW-1:0] s_in;
         always_comb begin
            c_in = neg_ff[gl][N] ? -x_ff[gl][N] : x_ff[gl][N];
            s_in = neg_ff[gl][N] ? -y_ff[gl][N] : y_ff[gl][N];
         end

         always_ff @(posedge clock) begin
            if (en) begin
               cos_ff[gl] <= c_in[TW-1:0];
               sin_ff[gl] <= s_in[TW-1:0];
            end
         end
      end
   endgenerate

   assign out_vld     = vld_ff[N+1];
   assign out_data.cx = cos_ff[0];
   assign out_data.sx = sin_ff[0];
   assign out_data.cy = cos_ff[1];
   assign out_data.sy = sin_ff[1];
   assign out_data.cz = cos_ff[2];
   assign out_data.sz = sin_ff[2];

endmodule

// File: design/rotm_matrix.sv
module rotm_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  rotm_pkg::trig_type in_data,
   output logic               out_vld,
   output rotm_pkg::rsp_type  out_data
);

   localparam int RW = rotm_pkg::RW;
   localparam int PW = rotm_pkg::PW;
   localparam int MW = rotm_pkg::MW;
   localparam int QF = rotm_pkg::QF;
   localparam int SH = QF - rotm_pkg::ELEM_FRAC_BITS;
   localparam logic signed [PW:0] HALF_Q = (PW+1)'(1) <<< (QF - 1);
   localparam logic signed [MW-1:0] HALF_E = MW'(1) <<< (SH - 1);
   localparam logic signed [MW-1:0] LIM = MW'(1) <<< rotm_pkg::ELEM_FRAC_BITS;

   logic [4:0] vld_ff;

   // stage a: ry*rx products
   logic signed [PW-1:0] pa01_ff, pa02_ff, pa21_ff, pa22_ff;
   logic signed [RW-1:0] a_cx_ff, a_sx_ff, a_cy_ff, a_nsy_ff, a_cz_ff, a_sz_ff;
   logic signed [RW-1:0] cx_s, sx_s, cy_s, sy_s, cz_s, sz_s;

   always_comb begin
      cx_s = RW'(in_data.cx);
      sx_s = RW'(in_data.sx);
      cy_s = RW'(in_data.cy);
      sy_s = RW'(in_data.sy);
      cz_s = RW'(in_data.cz);
      sz_s = RW'(in_data.sz);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa01_ff  <= PW'(-sy_s) * PW'(sx_s);
         pa02_ff  <= PW'(sy_s) * PW'(cx_s);
         pa21_ff  <= PW'(-cy_s) * PW'(sx_s);
         pa22_ff  <= PW'(cy_s) * PW'(cx_s);
         a_cx_ff  <= cx_s;
         a_sx_ff  <= sx_s;
         a_cy_ff  <= cy_s;
         a_nsy_ff <= -sy_s;
         a_cz_ff  <= cz_s;
         a_sz_ff  <= sz_s;
      end
   end

   // stage b: round the intermediate matrix t to q30
   function automatic logic signed [RW-1:0] rnd_q(input logic signed [PW:0] v);
      logic signed [PW:0] w;
      w = (v + HALF_Q) >>> QF;
      return w[RW-1:0];
   endfunction

   logic signed [RW-1:0] t00_ff, t01_ff, t02_ff, t11_ff, t12_ff;
   logic signed [RW-1:0] t20_ff, t21_ff, t22_ff, b_cz_ff, b_sz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t00_ff  <= a_cy_ff;
         t01_ff  <= rnd_q((PW+1)'(pa01_ff));
         t02_ff  <= rnd_q((PW+1)'(pa02_ff));
         t11_ff  <= a_cx_ff;
         t12_ff  <= a_sx_ff;
         t20_ff  <= a_nsy_ff;
         t21_ff  <= rnd_q((PW+1)'(pa21_ff));
         t22_ff  <= rnd_q((PW+1)'(pa22_ff));
         b_cz_ff <= a_cz_ff;
         b_sz_ff <= a_sz_ff;
      end
   end

   // stage c: rz*t products, the middle row of t is (0, cx, sx)
   logic signed [PW-1:0] q00_ff, q01a_ff, q01b_ff, q02a_ff, q02b_ff;
   logic signed [PW-1:0] q10_ff, q11a_ff, q11b_ff, q12a_ff, q12b_ff;
   logic signed [RW-1:0] c20_ff, c21_ff, c22_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         q00_ff  <= PW'(b_cz_ff) * PW'(t00_ff);
         q01a_ff <= PW'(b_cz_ff) * PW'(t01_ff);
         q01b_ff <= PW'(b_sz_ff) * PW'(t11_ff);
         q02a_ff <= PW'(b_cz_ff) * PW'(t02_ff);
         q02b_ff <= PW'(b_sz_ff) * PW'(t12_ff);
         q10_ff  <= PW'(-b_sz_ff) * PW'(t00_ff);
         q11a_ff <= PW'(-b_sz_ff) * PW'(t01_ff);
         q11b_ff <= PW'(b_cz_ff) * PW'(t11_ff);
         q12a_ff <= PW'(-b_sz_ff) * PW'(t02_ff);
         q12b_ff <= PW'(b_cz_ff) * PW'(t12_ff);
         c20_ff  <= t20_ff;
         c21_ff  <= t21_ff;
         c22_ff  <= t22_ff;
      end
   end

   // stage d: sum and round to q30
   logic signed [MW-1:0] m_ff [9];

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= MW'(rnd_q((PW+1)'(q00_ff)));
         m_ff[1] <= MW'(rnd_q((PW+1)'(q01a_ff) + (PW+1)'(q01b_ff)));
         m_ff[2] <= MW'(rnd_q((PW+1)'(q02a_ff) + (PW+1)'(q02b_ff)));
         m_ff[3] <= MW'(rnd_q((PW+1)'(q10_ff)));
         m_ff[4] <= MW'(rnd_q((PW+1)'(q11a_ff) + (PW+1)'(q11b_ff)));
         m_ff[5] <= MW'(rnd_q((PW+1)'(q12a_ff) + (PW+1)'(q12b_ff)));
         m_ff[6] <= MW'(c20_ff);
         m_ff[7] <= MW'(c21_ff);
         m_ff[8] <= MW'(c22_ff);
      end
   end

   // stage e: round to the element format and saturate
   function automatic logic signed [rotm_pkg::ELEM_W-1:0] to_elem(
      input logic signed [MW-1:0] v);
      logic signed [MW-1:0] w;
      w = (v + HALF_E) >>> SH;
      if (w > LIM) begin
         w = LIM;
      end else if (w < -LIM) begin
         w = -LIM;
      end
      return w[rotm_pkg::ELEM_W-1:0];
   endfunction

   rotm_pkg::rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.m11 <= to_elem(m_ff[0]);
         out_ff.m12 <= to_elem(m_ff[1]);
         out_ff.m13 <= to_elem(m_ff[2]);
         out_ff.m21 <= to_elem(m_ff[3]);
         out_ff.m22 <= to_elem(m_ff[4]);
         out_ff.m23 <= to_elem(m_ff[5]);
         out_ff.m31 <= to_elem(m_ff[6]);
         out_ff.m32 <= to_elem(m_ff[7]);
         out_ff.m33 <= to_elem(m_ff[8]);
      end
   end

   // valid bits follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_vld};
      end
   end

   assign out_vld  = vld_ff[4];
   assign out_data = out_ff;

endmodule

// File: design/rotm_checker.sv
module rotm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rotm_pkg::rsp_type rsp_payload
);

   // a blocked response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // no response right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // input is only held off by a blocked output
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");

   // diagonal elements stay within +-1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.m11 <= 16'sd16384) && (rsp_payload.m11 >= -16'sd16384)
         && (rsp_payload.m22 <= 16'sd16384) && (rsp_payload.m22 >= -16'sd16384)
         && (rsp_payload.m33 <= 16'sd16384) && (rsp_payload.m33 >= -16'sd16384))
      else $error("matrix element out of range");

endmodule

bind euler_xyz_rotation_matrix_core rotm_checker u_rotm_checker (.*);
